// ===== rtl/ultrasonic_echo_ranger_macros.svh =====
// assertion macros for the ultrasonic echo ranger rtl
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UER_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uer assertion failed");

// next-cycle implication, disabled during reset
`define UER_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uer assertion failed");

`endif

// ===== rtl/uer_pkg.sv =====
// shared types, constants and the divide-by-58 helper for the echo ranger
`default_nettype none

package uer_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned DistWidth  = 11;

   localparam logic [CountWidth-1:0] DefaultTicks = 16'd100;
   localparam logic [CountWidth-1:0] CountMax     = 16'hFFFF;

   // x / 58 == (x >> 1) / 29, then reciprocal multiply by ceil(2^21 / 29)
   localparam logic [31:0] Recip29 = 32'd72316;
   localparam int unsigned Recip29Shift = 21;

   // register indexes on the csr write channel
   typedef enum logic [0:0] {
      CSR_SETTLE_TICKS  = 1'b0,
      CSR_TRIGGER_TICKS = 1'b1
   } csr_index_type;

   // measurement phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SETTLE = 5'b00010,
      PH_TRIG   = 5'b00100,
      PH_WAIT   = 5'b01000,
      PH_HIGH   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [CountWidth-1:0] settle_ticks;
      logic [CountWidth-1:0] trigger_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  trigger_out;
      logic                  busy_res;
      logic                  done_res;
      logic [CountWidth-1:0] pulse_ticks;
      logic [DistWidth-1:0]  distance_cm;
   } result_type;

   function automatic logic [DistWidth-1:0] div58(input logic [CountWidth-1:0] x);
      logic [31:0] prod;
      prod = {17'd0, x[CountWidth-1:1]} * Recip29;
      return prod[Recip29Shift +: DistWidth];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/uer_fsm.sv =====
// trigger sequencing and echo width timing, one tick per step
`default_nettype none

`include "ultrasonic_echo_ranger_macros.svh"

module uer_fsm (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                start_req,
   input  wire logic                echo_level,
   input  wire uer_pkg::cfg_type    cfg,
   output uer_pkg::result_type      result
);

   uer_pkg::phase_type                phase_ff, phase_in, phase_eff;
   logic [uer_pkg::CountWidth-1:0]    phase_count_ff, phase_count_in, count_base, count_inc;
   logic [uer_pkg::CountWidth-1:0]    echo_count_ff, echo_count_in;
   logic [uer_pkg::CountWidth-1:0]    last_width_ff, last_width_in;
   logic [uer_pkg::DistWidth-1:0]     last_dist_ff, last_dist_in, echo_dist;
   logic                              trig, busy, done;

   // quotient of the running width, ready for the falling edge
   assign echo_dist = uer_pkg::div58(echo_count_ff);

   always_comb begin
      // a start in idle makes this same tick the first settle tick
      if (phase_ff == uer_pkg::PH_IDLE && start_req) begin
         phase_eff  = uer_pkg::PH_SETTLE;
         count_base = '0;
      end else begin
         phase_eff  = phase_ff;
         count_base = phase_count_ff;
      end
      count_inc = count_base + 16'd1;

      phase_in       = phase_eff;
      phase_count_in = count_base;
      echo_count_in  = echo_count_ff;
      last_width_in  = last_width_ff;
      last_dist_in   = last_dist_ff;
      trig           = 1'b0;
      busy           = 1'b1;
      done           = 1'b0;

      unique case (phase_eff)
         uer_pkg::PH_IDLE: begin
            busy = 1'b0;
         end
         uer_pkg::PH_SETTLE: begin
            phase_count_in = count_inc;
            if (count_inc >= cfg.settle_ticks) begin
               phase_in       = uer_pkg::PH_TRIG;
               phase_count_in = '0;
            end
         end
         uer_pkg::PH_TRIG: begin
            trig           = 1'b1;
            phase_count_in = count_inc;
            if (count_inc >= cfg.trigger_ticks) begin
               phase_in       = uer_pkg::PH_WAIT;
               phase_count_in = '0;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo_level) begin
               phase_in      = uer_pkg::PH_HIGH;
               echo_count_in = 16'd1;
            end
         end
         uer_pkg::PH_HIGH: begin
            if (echo_level) begin
               if (echo_count_ff != uer_pkg::CountMax) begin
                  echo_count_in = echo_count_ff + 16'd1;
               end
            end else begin
               last_width_in = echo_count_ff;
               last_dist_in  = echo_dist;
               echo_count_in = '0;
               phase_in      = uer_pkg::PH_IDLE;
               busy          = 1'b0;
               done          = 1'b1;
            end
         end
         default: begin
            phase_in       = uer_pkg::PH_IDLE;
            phase_count_in = '0;
            busy           = 1'b0;
         end
      endcase

      result.trigger_out = trig;
      result.busy_res    = busy;
      result.done_res    = done;
      result.pulse_ticks = last_width_in;
      result.distance_cm = last_dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= uer_pkg::PH_IDLE;
         phase_count_ff <= '0;
         echo_count_ff  <= '0;
         last_width_ff  <= '0;
         last_dist_ff   <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         phase_count_ff <= phase_count_in;
         echo_count_ff  <= echo_count_in;
         last_width_ff  <= last_width_in;
         last_dist_ff   <= last_dist_in;
      end
   end

   // echo falling edge always ends the measurement
   `UER_ASSERT_NEXT(a_high_fall_idle, clock, reset,
      step && phase_ff == uer_pkg::PH_HIGH && !echo_level, phase_ff == uer_pkg::PH_IDLE)
   // the width counter is only live while the echo is high
   `UER_ASSERT_SAME(a_echo_count_clear, clock, reset,
      phase_ff != uer_pkg::PH_HIGH, echo_count_ff == '0)
   // settle only ever moves on to the trigger pulse
   `UER_ASSERT_NEXT(a_settle_to_trig, clock, reset,
      step && phase_ff == uer_pkg::PH_SETTLE,
      phase_ff == uer_pkg::PH_SETTLE || phase_ff == uer_pkg::PH_TRIG)
   // latched distance tracks the latched width
   `UER_ASSERT_SAME(a_dist_matches, clock, reset,
      1'b1, last_dist_ff == uer_pkg::div58(last_width_ff))

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger.sv =====
// top level of the ultrasonic echo ranger: stream ports, csr bank, result register
`default_nettype none

// Ultrasonic echo ranger. Each req word is one microsecond tick carrying a start
// request and the sampled echo pin; each accepted word yields exactly one rsp
// word, in the next cycle, from a result register. One word is taken every clock
// cycle as long as rsp_tready keeps up: req_tready is high whenever the result
// register is empty or being drained, so throughput is one tick per cycle. From
// idle, a start request begins a measurement on that same tick: trigger low for
// settle_ticks ticks, high for trigger_ticks ticks, then a wait for the echo to
// rise with no timeout. Echo-high ticks are counted (saturating at 65535); on the
// tick the echo is seen low, done_res pulses and pulse_ticks / distance_cm (width
// / 58, cm) are latched. Starts are ignored while busy, and a register value of
// zero acts as one. Write the csr registers only while idle; csr_ready is always
// high.

module ultrasonic_echo_ranger (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] start_req, [1] echo_level, [7:2] zero
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [0] trigger_out, [1] busy_res, [2] done_res,
                                         // [18:3] pulse_ticks, [29:19] distance_cm,
                                         // [31:30] zero
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   uer_pkg::cfg_type    cfg_ff;
   uer_pkg::result_type result;
   uer_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                step;

   // result register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks  <= uer_pkg::DefaultTicks;
         cfg_ff.trigger_ticks <= uer_pkg::DefaultTicks;
      end else if (csr_valid && csr_ready) begin
         unique case (uer_pkg::csr_index_type'(csr_index))
            uer_pkg::CSR_SETTLE_TICKS:  cfg_ff.settle_ticks  <= csr_wdata;
            uer_pkg::CSR_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tick sequencer and echo timer
   uer_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start_req  (req_tdata[0]),
      .echo_level (req_tdata[1]),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_data_ff.distance_cm,
                        rsp_data_ff.pulse_ticks,
                        rsp_data_ff.done_res,
                        rsp_data_ff.busy_res,
                        rsp_data_ff.trigger_out};

endmodule

`default_nettype wire

// ===== sim/ultrasonic_echo_ranger_tb.sv =====
// self-checking testbench for the ultrasonic echo ranger: directed table, then random ticks
`default_nettype none

module ultrasonic_echo_ranger_tb;

   localparam int unsigned SoundDivisor = 58;
   localparam int unsigned HoldCycles   = 400;   // long receiver stall, fills the block
   localparam int unsigned HoldAfter    = 120;   // words received before the stall starts

   // one row of the directed table: a tick repeated reps times
   typedef struct {
      logic                 start;
      logic                 echo;
      int unsigned          reps;
      bit                   typed;
      uer_pkg::result_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [0] start_req, [1] echo_level, [7:2] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [0] trigger_out, [1] busy_res, [2] done_res,
                                   // [18:3] pulse_ticks, [29:19] distance_cm
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predictor state and its copy of the registers
   uer_pkg::phase_type rng_phase   = uer_pkg::PH_IDLE;
   logic [15:0]        tick_count  = '0;
   logic [15:0]        echo_width  = '0;
   logic [15:0]        held_width  = '0;
   logic [15:0]        settle_cfg  = uer_pkg::DefaultTicks;
   logic [15:0]        trigger_cfg = uer_pkg::DefaultTicks;

   uer_pkg::result_type expect_q[$];
   stim_row_type        stim_table[$];
   int unsigned       send_pct = 0;
   int unsigned       recv_pct = 0;
   int unsigned       words_sent = 0;
   int unsigned       rsp_count = 0;
   int unsigned       done_seen = 0;
   int unsigned       csr_writes = 0;
   int unsigned       errors = 0;

   ultrasonic_echo_ranger u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one microsecond tick of the ranger: advance the phase machine, return the word
   function automatic uer_pkg::result_type ranger_tick(input logic start, input logic echo);
      uer_pkg::result_type r;
      r.trigger_out = 1'b0;
      r.busy_res    = 1'b1;
      r.done_res    = 1'b0;
      if (rng_phase == uer_pkg::PH_IDLE) begin
         if (start) begin
            rng_phase  = uer_pkg::PH_SETTLE;
            tick_count = '0;
         end else begin
            r.busy_res = 1'b0;
         end
      end
      case (rng_phase)
         uer_pkg::PH_SETTLE: begin
            tick_count = tick_count + 16'd1;
            // a zero register still gives one tick, since the count is already 1
            if (tick_count >= settle_cfg) begin
               rng_phase  = uer_pkg::PH_TRIG;
               tick_count = '0;
            end
         end
         uer_pkg::PH_TRIG: begin
            r.trigger_out = 1'b1;
            tick_count = tick_count + 16'd1;
            if (tick_count >= trigger_cfg) begin
               rng_phase  = uer_pkg::PH_WAIT;
               tick_count = '0;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo) begin
               rng_phase  = uer_pkg::PH_HIGH;
               echo_width = 16'd1;
            end
         end
         uer_pkg::PH_HIGH: begin
            if (echo) begin
               if (echo_width != uer_pkg::CountMax) echo_width = echo_width + 16'd1;
            end else begin
               held_width = echo_width;
               echo_width = '0;
               rng_phase  = uer_pkg::PH_IDLE;
               r.busy_res = 1'b0;
               r.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      r.pulse_ticks = held_width;
      r.distance_cm = uer_pkg::DistWidth'(held_width / SoundDivisor);
      return r;
   endfunction

   // offer one tick; a typed row replaces the predicted word with its own
   task automatic send_word(input logic start, input logic echo,
                            input bit typed = 1'b0,
                            input uer_pkg::result_type typed_want = '0);
      uer_pkg::result_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, echo, start};
      do @(posedge clock); while (!req_tready);
      r = ranger_tick(start, echo);
      expect_q.push_back(typed ? typed_want : r);
      words_sent++;
   endtask

   // run the phase machine back to idle: echo up while waiting, down while high
   task automatic drain_phase();
      while (rng_phase != uer_pkg::PH_IDLE) send_word(1'b0, rng_phase == uer_pkg::PH_WAIT);
   endtask

   // block idle and every word back before a register write
   task automatic idle_block();
      drain_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input uer_pkg::csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == uer_pkg::CSR_SETTLE_TICKS) settle_cfg = val;
      else trigger_cfg = val;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(input logic start, input logic echo, input int unsigned reps,
                          input bit typed, input logic trig, input logic busy,
                          input logic done, input logic [15:0] pulse,
                          input logic [10:0] distance);
      stim_row_type row;
      row.start = start;
      row.echo  = echo;
      row.reps  = reps;
      row.typed = typed;
      row.want.trigger_out = trig;
      row.want.busy_res    = busy;
      row.want.done_res    = done;
      row.want.pulse_ticks = pulse;
      row.want.distance_cm = distance;
      stim_table.push_back(row);
   endtask

   // a full measurement with noise on the ignored inputs; cut_short leaves echo high
   task automatic measure_once(input bit cut_short);
      int unsigned filler;
      int unsigned wait_len;
      int unsigned width;
      drain_phase();
      send_word(1'b1, 1'($urandom_range(1)));
      filler = ((settle_cfg == 0) ? 1 : int'(settle_cfg))
             + ((trigger_cfg == 0) ? 1 : int'(trigger_cfg)) - 1;
      repeat (filler) send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
      wait_len = $urandom_range(0, 6);
      repeat (wait_len) send_word(1'($urandom_range(1)), 1'b0);
      // mostly short echoes, some long enough for a nonzero distance
      width = ($urandom_range(99) < 80) ? $urandom_range(1, 70) : $urandom_range(56, 180);
      repeat (width) send_word(1'($urandom_range(1)), 1'b1);
      if (!cut_short) send_word(1'($urandom_range(1)), 1'b0);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // result side: random back-pressure plus one long stall
   initial begin : rsp_side
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_count >= HoldAfter) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_pct);
         end
      end
   end

   // compare every received word with the oldest prediction
   always @(posedge clock) begin : rsp_check
      uer_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expect_q.size() == 0) begin
            $error("unexpected result word 0x%08h", rsp_tdata);
            errors++;
         end else begin
            want = expect_q.pop_front();
            if (want.done_res) done_seen++;
            check_field("trigger_out", want.trigger_out, rsp_tdata[0]);
            check_field("busy_res",    want.busy_res,    rsp_tdata[1]);
            check_field("done_res",    want.done_res,    rsp_tdata[2]);
            check_field("pulse_ticks", want.pulse_ticks, rsp_tdata[18:3]);
            check_field("distance_cm", want.distance_cm, rsp_tdata[29:19]);
         end
      end
   end

   initial begin : stimulus
      int unsigned seg;
      int unsigned target;
      int unsigned pick;
      int unsigned waited;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_pct = 22;
      recv_pct = 69;

      // directed part, at the reset register values of 100 and 100
      add_row(1'b0, 1'b0, 3,     1, 0, 0, 0, 16'd0, 11'd0);      // idle after reset
      add_row(1'b0, 1'b1, 2,     1, 0, 0, 0, 16'd0, 11'd0);      // echo ignored when idle
      add_row(1'b1, 1'b0, 1,     1, 0, 1, 0, 16'd0, 11'd0);      // start tick already settles
      add_row(1'b1, 1'b1, 99,    0, 0, 0, 0, 16'd0, 11'd0);      // rest of settle, noise ignored
      add_row(1'b1, 1'b1, 100,   1, 1, 1, 0, 16'd0, 11'd0);      // trigger pulse
      add_row(1'b0, 1'b0, 5,     1, 0, 1, 0, 16'd0, 11'd0);      // waiting for echo
      add_row(1'b0, 1'b1, 1,     1, 0, 1, 0, 16'd0, 11'd0);      // rise counts as one tick
      add_row(1'b0, 1'b0, 1,     1, 0, 0, 1, 16'd1, 11'd0);      // shortest echo
      add_row(1'b0, 1'b0, 2,     1, 0, 0, 0, 16'd1, 11'd0);      // width stays latched

      foreach (stim_table[i]) begin
         repeat (stim_table[i].reps)
            send_word(stim_table[i].start, stim_table[i].echo,
                      stim_table[i].typed, stim_table[i].want);
      end

      // random part in three idling regimes, each with its own register setting
      for (seg = 0; seg < 3; seg++) begin
         idle_block();
         case (seg)
            0: begin
               write_csr(uer_pkg::CSR_SETTLE_TICKS, 16'd1);
               write_csr(uer_pkg::CSR_TRIGGER_TICKS, 16'd1);
            end
            1: begin
               send_pct = 69;
               recv_pct = 22;
               write_csr(uer_pkg::CSR_SETTLE_TICKS, 16'd0);
               write_csr(uer_pkg::CSR_TRIGGER_TICKS, 16'd0);
            end
            default: begin
               send_pct = 0;
               recv_pct = 0;
               write_csr(uer_pkg::CSR_SETTLE_TICKS, 16'($urandom_range(2, 9)));
               write_csr(uer_pkg::CSR_TRIGGER_TICKS, 16'($urandom_range(2, 12)));
            end
         endcase
         target = words_sent + 120;
         while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) measure_once(1'b0);
            else if (pick < 78) measure_once(1'b1);
            else repeat ($urandom_range(1, 8))
               send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end

      // largest register values, the start of a settle phase at full rate
      idle_block();
      write_csr(uer_pkg::CSR_SETTLE_TICKS, 16'hFFFF);
      write_csr(uer_pkg::CSR_TRIGGER_TICKS, 16'hFFFF);
      send_word(1'b1, 1'b0);
      repeat (8) send_word(1'($urandom_range(1)), 1'($urandom_range(1)));

      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (expect_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (expect_q.size() != 0) begin
         $error("%0d result words never arrived", expect_q.size());
         errors++;
      end

      $display("run covered %0d tick words, %0d completed measurements, %0d register writes",
               words_sent, done_seen, csr_writes);
      $display("register settings ran from zero through the reset value to 65535");
      if (errors == 0) begin
         $display("ultrasonic_echo_ranger_tb: clean");
      end else begin
         $display("ultrasonic_echo_ranger_tb: errors");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #40000000;
      $display("ultrasonic_echo_ranger_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
